// ----- design/single_bin_iq_amplitude_phase_macros.svh -----
// Assertion macros shared by the single-bin I/Q meter modules.
`ifndef SINGLE_BIN_IQ_AMPLITUDE_PHASE_MACROS_SVH
`define SINGLE_BIN_IQ_AMPLITUDE_PHASE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBIQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbiq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SBIQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbiq assertion failed");

`endif

// ----- design/sbiq_pkg.sv -----
// Shared constants, types and table functions of the single-bin I/Q meter.
`default_nettype none
package sbiq_pkg;

   localparam int MAX_SAMPLES_DEF     = 16384;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam int RAW_W      = 16;
   localparam int MAG_W      = 24;
   localparam int DEG_W      = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_W     = 32;
   localparam int PERIOD_W   = 11;
   localparam int NPER_W     = 8;
   localparam int TOTAL_W    = 15;
   localparam int SPAN_W     = 18;
   localparam int SUM_W      = 48;
   localparam int SAMP_W     = 17;
   localparam int REF_W      = 16;
   localparam int PROD_W     = SAMP_W + REF_W;
   localparam int ENTRY_W    = 15;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [STEP_W-1:0]   PHASE_STEP_RST = 32'd143165577;
   localparam logic [PERIOD_W-1:0] PERIOD_RST     = 11'd30;
   localparam logic [NPER_W-1:0]   NPER_RST       = 8'd20;
   localparam logic [TOTAL_W-1:0]  TOTAL_RST      = 15'd660;

   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd4;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'd1024;
   localparam logic [NPER_W-1:0]   NPER_MIN   = 8'd5;
   localparam logic [NPER_W-1:0]   NPER_MAX   = 8'd255;
   localparam logic [TOTAL_W-1:0]  TOTAL_MIN  = 15'd2;

   localparam longint GAIN_Q30      = 64'sd652032874;
   localparam int     MAG_SCALE_W   = 30;
   localparam logic [MAG_SCALE_W-1:0] MAG_SCALE_Q24 = 30'd1017171284;

   localparam int ATAN_ENTRIES = 24;
   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP = 8'd0,
      CSR_PERIOD     = 8'd1,
      CSR_NPERIODS   = 8'd2,
      CSR_TOTAL      = 8'd3
   } csr_idx_type;

   typedef struct packed {
      logic                      busy;
      logic [TOTAL_W-1:0]        first;
      logic [SPAN_W-1:0]         span;
      logic [TOTAL_W-1:0]        total;
   } window_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]   i_sum;
      logic signed [SUM_W-1:0]   q_sum;
      logic                      window_ok;
      logic [SPAN_W-1:0]         span;
   } capture_type;

   // One quarter-wave sine entry in Q15, built by a rotation CORDIC at elaboration.
   function automatic logic [ENTRY_W-1:0] quarter_entry(input int j, input int stb,
                                                       input int steps);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint v;
      x = GAIN_Q30;
      y = 0;
      z = longint'(j) <<< (32 - stb);
      for (int i = 0; i < steps && i < ATAN_ENTRIES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TURNS[i]);
         end
      end
      v = (y + 64'sd16384) >>> 15;
      if (v < 0) begin
         v = 0;
      end else if (v > 32767) begin
         v = 32767;
      end
      return v[ENTRY_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- design/sbiq_if.sv -----
// Handshake channels of the single-bin I/Q meter: samples, results and register writes.
`default_nettype none
interface sbiq_req_if;
   logic                              valid;
   logic                              ready;
   logic [sbiq_pkg::RAW_W-1:0]        raw_sample;
   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

interface sbiq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sbiq_pkg::MAG_W-1:0]        magnitude_uv;
   logic signed [sbiq_pkg::DEG_W-1:0] phase_deg;
   logic                              window_ok;
   modport source (output valid, output magnitude_uv, output phase_deg,
                   output window_ok, input ready);
   modport sink (input valid, input magnitude_uv, input phase_deg,
                 input window_ok, output ready);
endinterface

interface sbiq_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sbiq_pkg::CSR_IDX_W-1:0]    index;
   logic [sbiq_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/sbiq_window.sv -----
// Configuration registers and the sequential computation of the correlation window.
`default_nettype none
module sbiq_window #(
   parameter int MAX_SAMPLES = sbiq_pkg::MAX_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sbiq_csr_if.sink                        csr,
   output logic [sbiq_pkg::STEP_W-1:0]     phase_step,
   output sbiq_pkg::window_type            win
);
   import sbiq_pkg::*;

   localparam int CLAMP_W = TOTAL_W + 2;
   localparam logic [CLAMP_W-1:0] TOTAL_MAX = CLAMP_W'(MAX_SAMPLES);
   localparam int DIV_CNT_W = $clog2(TOTAL_W);

   typedef enum logic [2:0] {W_LOAD, W_CHECK, W_DIV, W_MUL, W_DONE} state_type;

   logic [STEP_W-1:0]   phase_step_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [NPER_W-1:0]   nper_ff;
   logic [TOTAL_W-1:0]  total_ff;

   state_type           state_ff;
   logic [PERIOD_W-1:0] p_ff;
   logic [TOTAL_W-1:0]  t_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [TOTAL_W-1:0]  num_ff;
   logic [PERIOD_W-1:0] rem_ff;
   logic [TOTAL_W-1:0]  quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [TOTAL_W-1:0]  first_ff;

   logic                write;
   logic [PERIOD_W-1:0] p_c;
   logic [NPER_W-1:0]   n_c;
   logic [TOTAL_W-1:0]  t_c;
   logic [PERIOD_W:0]   rem_shift;
   logic                rem_ge;
   logic                fits;

   assign csr.ready = 1'b1;
   assign write     = csr.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RST;
         period_ff     <= PERIOD_RST;
         nper_ff       <= NPER_RST;
         total_ff      <= TOTAL_RST;
      end else if (write) begin
         unique case (csr_idx_type'(csr.index))
            CSR_PHASE_STEP: phase_step_ff <= csr.data[STEP_W-1:0];
            CSR_PERIOD:     period_ff     <= csr.data[PERIOD_W-1:0];
            CSR_NPERIODS:   nper_ff       <= csr.data[NPER_W-1:0];
            CSR_TOTAL:      total_ff      <= csr.data[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      p_c = (period_ff < PERIOD_MIN) ? PERIOD_MIN :
            ((period_ff > PERIOD_MAX) ? PERIOD_MAX : period_ff);
      n_c = (nper_ff < NPER_MIN) ? NPER_MIN : nper_ff;
      if (total_ff < TOTAL_MIN) begin
         t_c = TOTAL_MIN;
      end else if ({2'b00, total_ff} > TOTAL_MAX) begin
         t_c = TOTAL_MAX[TOTAL_W-1:0];
      end else begin
         t_c = total_ff;
      end
      rem_shift = {rem_ff, num_ff[TOTAL_W-1]};
      rem_ge    = rem_shift >= {1'b0, p_ff};
      fits      = ({1'b0, t_ff} > {5'd0, p_ff}) &&
                  ((span_ff - 1'b1) < SPAN_W'({1'b0, t_ff} - {5'd0, p_ff}));
   end

   // The window starts at the first multiple of the period that is at least
   // (total - period) - (span - 1), so the division runs on total - span.
   always_ff @(posedge clock) begin
      if (reset || write) begin
         state_ff <= W_LOAD;
      end else begin
         unique case (state_ff)
            W_LOAD: begin
               p_ff     <= p_c;
               t_ff     <= t_c;
               span_ff  <= SPAN_W'(n_c) * SPAN_W'(p_c);
               state_ff <= W_CHECK;
            end
            W_CHECK: begin
               num_ff <= TOTAL_W'({3'd0, t_ff} - span_ff);
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= '0;
               if (fits) begin
                  state_ff <= W_DIV;
               end else begin
                  first_ff <= '0;
                  state_ff <= W_DONE;
               end
            end
            W_DIV: begin
               rem_ff <= rem_ge ? PERIOD_W'(rem_shift - {1'b0, p_ff}) : rem_shift[PERIOD_W-1:0];
               quo_ff <= {quo_ff[TOTAL_W-2:0], rem_ge};
               num_ff <= {num_ff[TOTAL_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_CNT_W'(TOTAL_W - 1)) begin
                  state_ff <= W_MUL;
               end
            end
            W_MUL: begin
               first_ff <= TOTAL_W'(quo_ff * TOTAL_W'(p_ff));
               state_ff <= W_DONE;
            end
            W_DONE: state_ff <= W_DONE;
            default: state_ff <= W_LOAD;
         endcase
      end
   end

   assign phase_step = phase_step_ff;
   assign win.busy   = state_ff != W_DONE;
   assign win.first  = first_ff;
   assign win.span   = span_ff;
   assign win.total  = t_ff;

endmodule
`default_nettype wire

// ----- design/sbiq_front.sv -----
// Sample front end: NCO, reference lookup, window gating and I/Q accumulation.
`default_nettype none
module sbiq_front #(
   parameter int SINE_TABLE_BITS = sbiq_pkg::SINE_TABLE_BITS_DEF,
   parameter int CORDIC_STEPS    = sbiq_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sbiq_req_if.sink                        req,
   input  logic [sbiq_pkg::STEP_W-1:0]     phase_step,
   input  sbiq_pkg::window_type            win,
   input  logic [sbiq_pkg::QCNT_W-1:0]     queue_count,
   output logic                            push,
   output sbiq_pkg::capture_type           entry
);
   import sbiq_pkg::*;

   localparam int QW  = SINE_TABLE_BITS - 2;
   localparam int QN  = 1 << QW;
   localparam int END_W = SPAN_W + 1;

   logic [ENTRY_W-1:0] qtab [QN+1];

   for (genvar g = 0; g <= QN; g++) begin : g_qtab
      localparam logic [ENTRY_W-1:0] ENTRY = quarter_entry(g, SINE_TABLE_BITS, CORDIC_STEPS);
      assign qtab[g] = ENTRY;
   end

   function automatic logic signed [REF_W-1:0] wave(input logic [SINE_TABLE_BITS-1:0] idx);
      logic [1:0]             quad;
      logic [QW:0]            j;
      logic [QW:0]            k;
      logic signed [REF_W-1:0] mag;
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      j    = {1'b0, idx[QW-1:0]};
      k    = quad[0] ? ((QW+1)'(QN) - j) : j;
      mag  = signed'({1'b0, qtab[k]});
      return quad[1] ? -mag : mag;
   endfunction

   logic [TOTAL_W-1:0]        index_ff;
   logic [STEP_W-1:0]         nco_ff;

   logic                      valid_a_ff;
   logic                      last_a_ff;
   logic                      win_a_ff;
   logic                      ok_a_ff;
   logic [SPAN_W-1:0]         span_a_ff;
   logic signed [SAMP_W-1:0]  samp_a_ff;
   logic signed [REF_W-1:0]   cos_a_ff;
   logic signed [REF_W-1:0]   sin_a_ff;

   logic                      valid_b_ff;
   logic                      last_b_ff;
   logic                      win_b_ff;
   logic                      ok_b_ff;
   logic [SPAN_W-1:0]         span_b_ff;
   logic signed [PROD_W-1:0]  pi_b_ff;
   logic signed [PROD_W-1:0]  pq_b_ff;

   logic signed [SUM_W-1:0]   i_sum_ff;
   logic signed [SUM_W-1:0]   q_sum_ff;
   logic signed [SUM_W-1:0]   i_sum_in;
   logic signed [SUM_W-1:0]   q_sum_in;

   logic                      accept;
   logic                      last;
   logic                      in_win;
   logic                      ok;
   logic [END_W-1:0]          win_end;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [QCNT_W:0]           pending;

   // Each capture end still in the pipe needs a queue slot of its own.
   assign pending   = {1'b0, queue_count} + (QCNT_W+1)'(valid_a_ff && last_a_ff)
                      + (QCNT_W+1)'(valid_b_ff && last_b_ff);
   assign req.ready = !win.busy && (pending < (QCNT_W+1)'(QDEPTH));
   assign accept    = req.valid && req.ready;

   always_comb begin
      win_end = END_W'(win.first) + END_W'(win.span);
      in_win  = (index_ff >= win.first) && (END_W'(index_ff) < win_end);
      last    = ((TOTAL_W+1)'(index_ff) + 1'b1) >= (TOTAL_W+1)'(win.total);
      ok      = win_end <= END_W'(win.total);
      tab_idx = nco_ff[STEP_W-1 -: SINE_TABLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         nco_ff     <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         i_sum_ff   <= '0;
         q_sum_ff   <= '0;
      end else begin
         valid_a_ff <= accept;
         valid_b_ff <= valid_a_ff;
         if (accept) begin
            index_ff <= last ? '0 : index_ff + 1'b1;
            nco_ff   <= last ? '0 : nco_ff + phase_step;
         end
         if (valid_b_ff) begin
            i_sum_ff <= last_b_ff ? '0 : i_sum_in;
            q_sum_ff <= last_b_ff ? '0 : q_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_a_ff <= last;
         win_a_ff  <= in_win;
         ok_a_ff   <= ok;
         span_a_ff <= win.span;
         // Offset binary to two's complement: flip the top bit and sign-extend.
         samp_a_ff <= signed'({~req.raw_sample[RAW_W-1], ~req.raw_sample[RAW_W-1],
                               req.raw_sample[RAW_W-2:0]});
         cos_a_ff  <= wave(tab_idx + SINE_TABLE_BITS'(QN));
         sin_a_ff  <= wave(tab_idx);
      end
      last_b_ff <= last_a_ff;
      win_b_ff  <= win_a_ff;
      ok_b_ff   <= ok_a_ff;
      span_b_ff <= span_a_ff;
      pi_b_ff   <= samp_a_ff * cos_a_ff;
      pq_b_ff   <= samp_a_ff * sin_a_ff;
   end

   always_comb begin
      i_sum_in = win_b_ff ? i_sum_ff + SUM_W'(pi_b_ff) : i_sum_ff;
      q_sum_in = win_b_ff ? q_sum_ff - SUM_W'(pq_b_ff) : q_sum_ff;
   end

   assign push            = valid_b_ff && last_b_ff;
   assign entry.i_sum     = i_sum_in;
   assign entry.q_sum     = q_sum_in;
   assign entry.window_ok = ok_b_ff;
   assign entry.span      = span_b_ff;

endmodule
`default_nettype wire

// ----- design/sbiq_queue.sv -----
// Short queue of finished capture sums between the front end and the back end.
`default_nettype none
module sbiq_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sbiq_pkg::capture_type       push_data,
   input  logic                        pop,
   output sbiq_pkg::capture_type       pop_data,
   output logic                        not_empty,
   output logic [sbiq_pkg::QCNT_W-1:0] count
);
   import sbiq_pkg::*;

`include "single_bin_iq_amplitude_phase_macros.svh"

   capture_type         mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   assign pop_data  = mem[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

   `SBIQ_ASSERT_IMP(a_no_overflow, clock, reset, push, (count_ff < QCNT_W'(QDEPTH)) || pop)
   `SBIQ_ASSERT_IMP(a_no_underflow, clock, reset, pop, count_ff != '0)
   `SBIQ_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == QCNT_W'($past(count_ff) + 1'b1))

endmodule
`default_nettype wire

// ----- design/sbiq_back.sv -----
// Back end: vectoring CORDIC, magnitude scaling by a serial divider, phase in degrees.
`default_nettype none
module sbiq_back #(
   parameter int CORDIC_STEPS = sbiq_pkg::CORDIC_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  sbiq_pkg::capture_type       q_data,
   output logic                        q_pop,
   sbiq_rsp_if.source                  rsp
);
   import sbiq_pkg::*;

`include "single_bin_iq_amplitude_phase_macros.svh"

   localparam int XW     = SUM_W + 3;
   localparam int XU_W   = XW - 1;
   localparam int HALF_W = XU_W / 2;
   localparam int MP_W   = HALF_W + MAG_SCALE_W;
   localparam int ZW     = 34;
   localparam int PW     = XU_W + MAG_SCALE_W + 1;
   localparam int DROP   = 39;
   localparam int TW     = PW - DROP;
   localparam int CNT_W  = $clog2(TW);
   localparam int DEGP_W = ZW + 6;

   typedef enum logic [2:0] {B_IDLE, B_ROT, B_MUL_LO, B_MUL_HI, B_DIV, B_OUT} state_type;

   state_type                state_ff;
   logic signed [XW-1:0]     x_ff;
   logic signed [XW-1:0]     y_ff;
   logic signed [ZW-1:0]     z_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     zero_ff;
   logic                     ok_ff;
   logic [SPAN_W-1:0]        span_ff;
   logic [PW-1:0]            prod_ff;
   logic [SPAN_W-1:0]        rem_ff;
   logic [TW-1:0]            quo_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic signed [DEG_W-1:0]  deg_ff;

   logic signed [XW-1:0]     i_ext;
   logic signed [XW-1:0]     q_ext;
   logic signed [XW-1:0]     dx;
   logic signed [XW-1:0]     dy;
   logic signed [ZW-1:0]     atan;
   logic signed [ZW-1:0]     zc;
   logic signed [DEGP_W-1:0] deg_full;
   logic [XU_W-1:0]          xu;
   logic [MP_W-1:0]          mul_lo;
   logic [MP_W-1:0]          mul_hi;
   logic [SPAN_W:0]          rem_shift;
   logic                     rem_ge;
   logic [TW-1:0]            quo_next;

   localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd2147483648);

   always_comb begin
      i_ext     = XW'(q_data.i_sum);
      q_ext     = XW'(q_data.q_sum);
      dx        = y_ff >>> cnt_ff;
      dy        = x_ff >>> cnt_ff;
      atan      = ZW'({1'b0, ATAN_TURNS[cnt_ff[4:0]]});
      if (z_ff > Z_HALF) begin
         zc = Z_HALF;
      end else if (z_ff < -Z_HALF) begin
         zc = -Z_HALF;
      end else begin
         zc = z_ff;
      end
      deg_full  = DEGP_W'(zc) * DEGP_W'(45) + DEGP_W'(64'sd2097152);
      xu        = x_ff[XW-1] ? '0 : x_ff[XU_W-1:0];
      mul_lo    = MP_W'(xu[HALF_W-1:0]) * MP_W'(MAG_SCALE_Q24);
      mul_hi    = MP_W'(xu[XU_W-1:HALF_W]) * MP_W'(MAG_SCALE_Q24);
      rem_shift = {rem_ff, prod_ff[PW-1]};
      rem_ge    = rem_shift >= {1'b0, span_ff};
      quo_next  = {quo_ff[TW-2:0], rem_ge};
   end

   assign q_pop = (state_ff == B_IDLE) && q_valid;

   // Rounding is folded in by adding half the divisor before the divide,
   // and the fixed power-of-two part of the divisor is a dropped bit range.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  zero_ff <= (q_data.i_sum == '0) && (q_data.q_sum == '0);
                  ok_ff   <= q_data.window_ok;
                  span_ff <= q_data.span;
                  cnt_ff  <= '0;
                  if (q_data.i_sum < 0) begin
                     x_ff <= -i_ext;
                     y_ff <= -q_ext;
                     z_ff <= (q_data.q_sum >= 0) ? Z_HALF : -Z_HALF;
                  end else begin
                     x_ff <= i_ext;
                     y_ff <= q_ext;
                     z_ff <= '0;
                  end
                  if ((q_data.i_sum == '0) && (q_data.q_sum == '0)) begin
                     mag_ff   <= '0;
                     deg_ff   <= '0;
                     state_ff <= B_OUT;
                  end else begin
                     state_ff <= B_ROT;
                  end
               end
            end
            B_ROT: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan;
               end else begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= B_MUL_LO;
               end
            end
            B_MUL_LO: begin
               deg_ff   <= deg_full[22 +: DEG_W];
               prod_ff  <= PW'(mul_lo) + (PW'(span_ff) << (DROP - 1));
               state_ff <= B_MUL_HI;
            end
            B_MUL_HI: begin
               prod_ff  <= prod_ff + (PW'(mul_hi) << HALF_W);
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               rem_ff  <= rem_ge ? SPAN_W'(rem_shift - {1'b0, span_ff}) : rem_shift[SPAN_W-1:0];
               quo_ff  <= quo_next;
               prod_ff <= {prod_ff[PW-2:0], 1'b0};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(TW - 1)) begin
                  mag_ff   <= (quo_next[TW-1:MAG_W] != '0) ? '1 : quo_next[MAG_W-1:0];
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (rsp.ready) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp.valid        = state_ff == B_OUT;
   assign rsp.magnitude_uv = mag_ff;
   assign rsp.phase_deg    = deg_ff;
   assign rsp.window_ok    = ok_ff;

   `SBIQ_ASSERT_IMP(a_div_nonzero, clock, reset, state_ff == B_DIV, span_ff != '0)
   `SBIQ_ASSERT_IMP(a_zero_result, clock, reset, (state_ff == B_OUT) && zero_ff, (mag_ff == '0) && (deg_ff == '0))
   `SBIQ_ASSERT_NXT(a_rot_done, clock, reset, (state_ff == B_ROT) && (cnt_ff == CNT_W'(CORDIC_STEPS - 1)), state_ff == B_MUL_LO)

endmodule
`default_nettype wire

// ----- design/single_bin_iq_amplitude_phase.sv -----
// Single-bin I/Q amplitude and phase meter, top level.
//
// req_chan takes one raw amplifier code per transfer, one transfer per cycle while it is ready.
// Each capture is total_samples codes; the last code of a capture yields one
// rsp_chan transfer with magnitude (uV, 8 fraction bits), phase (degrees,
// 7 fraction bits) and a flag that the correlation window fitted.
// csr_chan writes phase_step, period_samples, num_periods and total_samples
// by index 0 to 3; it is always ready.
// After reset and after every register write the window start is recomputed
// by a serial divider, during which req_chan is not ready.
// A result passes from the last code of a capture through two pipeline stages,
// the queue, one load step, the CORDIC rotations, two multiply steps and a
// serial magnitude divide. The back end handles one capture at a time;
// a four-entry queue of capture sums lets sample intake continue while results
// wait, and req_chan stalls only while the window is recomputed or when the
// queue cannot take the captures in flight.
// A stalled rsp_chan holds its result until the transfer and stops the back end.
`default_nettype none
module single_bin_iq_amplitude_phase #(
   parameter int MAX_SAMPLES     = sbiq_pkg::MAX_SAMPLES_DEF,
   parameter int SINE_TABLE_BITS = sbiq_pkg::SINE_TABLE_BITS_DEF,
   parameter int CORDIC_STEPS    = sbiq_pkg::CORDIC_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sbiq_req_if.sink      req_chan,
   sbiq_rsp_if.source    rsp_chan,
   sbiq_csr_if.sink      csr_chan
);
   import sbiq_pkg::*;

   logic [STEP_W-1:0]  phase_step;
   window_type         win;
   logic               push;
   capture_type        push_data;
   logic               pop;
   capture_type        pop_data;
   logic               not_empty;
   logic [QCNT_W-1:0]  count;

   sbiq_window #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_chan),
      .phase_step (phase_step),
      .win        (win)
   );

   sbiq_front #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS),
      .CORDIC_STEPS   (CORDIC_STEPS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .phase_step  (phase_step),
      .win         (win),
      .queue_count (count),
      .push        (push),
      .entry       (push_data)
   );

   sbiq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty),
      .count     (count)
   );

   sbiq_back #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_chan)
   );

endmodule
`default_nettype wire

// ----- sim/iq_meter_checker.sv -----
// Checker of the single-bin I/Q meter: predicts each capture result and compares it.
`default_nettype none
module iq_meter_checker (
   input  logic   clock,
   input  logic   reset,
   sbiq_req_if    req,
   sbiq_rsp_if    rsp,
   sbiq_csr_if    csr,
   output int     errors,
   output int     pending
);
   import sbiq_pkg::*;

   typedef struct {
      logic [MAG_W-1:0]        magnitude;
      logic signed [DEG_W-1:0] phase;
      logic                    fitted;
   } meter_result_type;

   meter_result_type expected_results[$];

   // Quarter-wave sine in Q15, entries 0 to 256.
   longint quarter_sine[0:256];

   logic [31:0]   step_reg;
   logic [10:0]   period_reg;
   logic [7:0]    nper_reg;
   logic [14:0]   total_reg;
   int unsigned   win_first;
   longint        i_acc;
   longint        q_acc;
   int unsigned   sample_pos;
   logic [31:0]   nco;

   function automatic longint sine_entry(int j);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint v;
      x = GAIN_Q30;
      y = 0;
      z = longint'(j) <<< 22;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ATAN_TURNS[i]);
         end
      end
      v = (y + 16384) >>> 15;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   function automatic longint reference_wave(int unsigned idx);
      int unsigned quad;
      int unsigned j;
      quad = (idx >> 8) & 3;
      j = idx & 255;
      case (quad)
         0: return quarter_sine[j];
         1: return quarter_sine[256 - j];
         2: return -quarter_sine[j];
         default: return -quarter_sine[256 - j];
      endcase
   endfunction

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int unsigned eff_period();
      return clamp_u(period_reg, 4, 1024);
   endfunction

   function automatic int unsigned eff_nper();
      return clamp_u(nper_reg, 5, 255);
   endfunction

   function automatic int unsigned eff_total();
      return clamp_u(total_reg, 2, MAX_SAMPLES_DEF);
   endfunction

   function automatic void place_window();
      int unsigned p;
      int unsigned span;
      int unsigned t;
      int unsigned gap;
      p = eff_period();
      span = eff_nper() * p;
      t = eff_total();
      win_first = 0;
      if (t > p && span - 1 < t - p) begin
         gap = (t - p) - (span - 1);
         win_first = ((gap + p - 1) / p) * p;
      end
   endfunction

   function automatic void accumulate_sample(logic [RAW_W-1:0] raw);
      longint s;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint deg;
      int unsigned span;
      int unsigned idx;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      meter_result_type r;
      s = longint'(raw) - 32768;
      span = eff_nper() * eff_period();
      idx = nco >> 22;
      if (sample_pos >= win_first && sample_pos < win_first + span) begin
         i_acc += s * reference_wave(idx + 256);
         q_acc -= s * reference_wave(idx);
      end
      nco += step_reg;
      if (sample_pos + 1 < eff_total()) begin
         sample_pos++;
         return;
      end
      x = i_acc;
      y = q_acc;
      z = 0;
      if (x == 0 && y == 0) begin
         r.magnitude = '0;
         r.phase = '0;
      end else begin
         // A vector in the left half plane is first turned by half a turn.
         if (x < 0) begin
            z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx;
               y -= dy;
               z += longint'(ATAN_TURNS[i]);
            end else begin
               x -= dx;
               y += dy;
               z -= longint'(ATAN_TURNS[i]);
            end
         end
         if (z > (64'sd1 <<< 31)) z = 64'sd1 <<< 31;
         if (z < -(64'sd1 <<< 31)) z = -(64'sd1 <<< 31);
         deg = (z * 45 + (64'sd1 <<< 21)) >>> 22;
         r.phase = deg[DEG_W-1:0];
         if (x < 0) x = 0;
         den = 128'(span) << 39;
         num = 128'(x) * 128'(MAG_SCALE_Q24) + (den >> 1);
         quo = num / den;
         r.magnitude = (quo > 128'hFFFFFF) ? 24'hFFFFFF : quo[MAG_W-1:0];
      end
      r.fitted = (win_first + span <= eff_total());
      expected_results.push_back(r);
      i_acc = 0;
      q_acc = 0;
      sample_pos = 0;
      nco = 0;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   initial begin
      errors = 0;
      for (int j = 0; j <= 256; j++) quarter_sine[j] = sine_entry(j);
   end

   always @(posedge clock) begin
      meter_result_type w;
      if (reset) begin
         step_reg = PHASE_STEP_RST;
         period_reg = PERIOD_RST;
         nper_reg = NPER_RST;
         total_reg = TOTAL_RST;
         i_acc = 0;
         q_acc = 0;
         sample_pos = 0;
         nco = 0;
         expected_results.delete();
         place_window();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result count", 1, 0);
            end else begin
               w = expected_results[0];
               expected_results.delete(0);
               if (rsp.magnitude_uv !== w.magnitude)
                  report_mismatch("magnitude_uv", rsp.magnitude_uv, w.magnitude);
               if (rsp.phase_deg !== w.phase)
                  report_mismatch("phase_deg", rsp.phase_deg, w.phase);
               if (rsp.window_ok !== w.fitted)
                  report_mismatch("window_ok", rsp.window_ok, w.fitted);
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr_idx_type'(csr.index))
               CSR_PHASE_STEP: step_reg = csr.data;
               CSR_PERIOD:     period_reg = csr.data[10:0];
               CSR_NPERIODS:   nper_reg = csr.data[7:0];
               CSR_TOTAL:      total_reg = csr.data[14:0];
               default: ;
            endcase
            place_window();
         end
         if (req.valid && req.ready) accumulate_sample(req.raw_sample);
      end
      pending <= expected_results.size();
   end
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Top of the single-bin I/Q meter testbench: clock, reset, stimulus and verdict.
`default_nettype none
module tb;
   import sbiq_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   pending;
   int   cycles = 0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   hold_left = 0;
   int   items_sent = 0;

   sbiq_req_if req ();
   sbiq_rsp_if rsp ();
   sbiq_csr_if csr ();

   single_bin_iq_amplitude_phase dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   iq_meter_checker checker_i (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .csr     (csr),
      .errors  (errors),
      .pending (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: a long hold-off when one is asked, otherwise random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_sample(logic [RAW_W-1:0] raw);
      req.valid <= 1'b1;
      req.raw_sample <= raw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected result has been transferred and the back end is quiet.
   task automatic drain();
      req.valid <= 1'b0;
      repeat (3) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(9))
         0: return 16'd32768;
         1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic set_idle_mode(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 79; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 79; end
         default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
   endtask

   initial begin
      int phase_no;
      int count;
      int unsigned per;
      req.valid = 1'b0;
      req.raw_sample = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One capture with the register values after reset.
      for (int k = 0; k < 660; k++) send_sample(pick_raw());
      drain();

      // Directed: clamped registers, extreme codes, window longer than the capture.
      write_reg(CSR_TOTAL, 32'd0);
      write_reg(CSR_PERIOD, 32'd2047);
      write_reg(CSR_NPERIODS, 32'd255);
      write_reg(CSR_PHASE_STEP, 32'hFFFFFFFF);
      send_sample(16'h0000); send_sample(16'hFFFF);
      send_sample(16'h8000); send_sample(16'h0001);
      send_sample(16'hAAAA); send_sample(16'h5555);
      send_sample(16'h7FFF); send_sample(16'hFFFE);
      send_sample(16'h0000); send_sample(16'h0000);
      send_sample(16'hFFFF); send_sample(16'hFFFF);
      drain();
      // All codes at the offset give zero sums.
      write_reg(CSR_TOTAL, 32'd4);
      repeat (4) send_sample(16'd32768);
      drain();
      // A register write in the middle of a capture ends it on the next sample.
      write_reg(CSR_PERIOD, 32'd4);
      write_reg(CSR_NPERIODS, 32'd5);
      write_reg(CSR_TOTAL, 32'd40);
      write_reg(CSR_PHASE_STEP, 32'h40000000);
      repeat (3) send_sample(pick_raw());
      drain();
      write_reg(CSR_TOTAL, 32'd2);
      send_sample(pick_raw());
      drain();

      // The receiver holds off while the sender keeps offering short captures.
      set_idle_mode(0);
      hold_left = 3000;
      for (int k = 0; k < 40; k++) send_sample(pick_raw());
      drain();

      // A capture length above the limit is clamped; a shorter length written
      // later ends that capture on the next sample.
      write_reg(CSR_TOTAL, 32'd32767);
      write_reg(CSR_PERIOD, 32'd2047);
      write_reg(CSR_NPERIODS, 32'd255);
      write_reg(CSR_PHASE_STEP, 32'd0);
      set_idle_mode(3);
      for (int k = 0; k < 100; k++) send_sample(pick_raw());
      drain();
      write_reg(CSR_TOTAL, 32'd2);
      send_sample(pick_raw());
      drain();

      phase_no = 0;
      while (items_sent < 1800) begin
         set_idle_mode(phase_no);
         per = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(4, 40);
         if ($urandom_range(1)) write_reg(CSR_PERIOD, per);
         if ($urandom_range(1))
            write_reg(CSR_NPERIODS, ($urandom_range(7) == 0) ? $urandom_range(255)
                                                            : $urandom_range(0, 12));
         if ($urandom_range(1))
            write_reg(CSR_TOTAL, ($urandom_range(15) == 0) ? $urandom_range(32767) % 2500
                                                          : $urandom_range(0, 150));
         if ($urandom_range(2) != 0)
            write_reg(CSR_PHASE_STEP, ($urandom_range(1) && per != 0) ? 32'hFFFFFFFF / per
                                                                     : $urandom);
         count = $urandom_range(10, 200);
         for (int k = 0; k < count; k++) send_sample(pick_raw());
         drain();
         phase_no++;
      end

      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
